>>> rtl/spm_pkg.sv
// ============================================================================
// spm_pkg - shared types and constants for the servo PWM mapper
// Word layouts, register indexes, window codes and the state encodings used
// by the mapper lanes and the top-level sequencer.
// ============================================================================
package spm_pkg;

    // Channel and field widths
    localparam int NCH      = 4;
    localparam int POS_W    = 12;
    localparam int PWM_W    = 16;
    localparam int PROD_W   = POS_W + PWM_W;
    localparam int DIV_W    = 12;
    localparam int MUL_STEPS = POS_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_POT_LOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POT_HIGH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_LOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRIP_PWM_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SELECT = 3'd5;

    // Window select codes and their lengths
    localparam logic [1:0] WSEL_NONE = 2'd0;
    localparam logic [1:0] WSEL_5    = 2'd1;
    localparam logic [1:0] WSEL_10   = 2'd2;
    localparam logic [1:0] WSEL_15   = 2'd3;

    localparam int WIN_5  = 5;
    localparam int WIN_10 = 10;
    localparam int WIN_15 = 15;

    // Reset values of the configuration registers
    localparam logic [POS_W-1:0] RST_POT_LOW       = 12'd0;
    localparam logic [POS_W-1:0] RST_POT_HIGH      = 12'd4095;
    localparam logic [PWM_W-1:0] RST_PWM_LOW       = 16'd1000;
    localparam logic [PWM_W-1:0] RST_PWM_HIGH      = 16'd2000;
    localparam logic [PWM_W-1:0] RST_GRIP_PWM_HIGH = 16'd1900;

    // Input word: four joint positions and the filter flag
    typedef struct packed {
        logic [POS_W-1:0] base_position;
        logic [POS_W-1:0] elbow_position;
        logic [POS_W-1:0] wrist_position;
        logic [POS_W-1:0] grip_position;
        logic             filter_enable;
    } t_in_word;

    // Output word: four PWM compare values
    typedef struct packed {
        logic [PWM_W-1:0] base_compare;
        logic [PWM_W-1:0] elbow_compare;
        logic [PWM_W-1:0] wrist_compare;
        logic [PWM_W-1:0] grip_compare;
    } t_out_word;

    // Commands from the sequencer to one lane
    typedef struct packed {
        logic start_map;
        logic start_avg;
    } t_lane_ctl;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_MUL,
        LN_DIVM,
        LN_DIVA
    } t_lane_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_AVG,
        ST_DONE
    } t_spm_state;

endpackage

>>> rtl/spm_ram.sv
// ============================================================================
// spm_ram - generic single-port-write, registered-read RAM
// One write and one read address per cycle; read data is registered and
// appears in the cycle after the read enable, holding until the next read.
// ============================================================================
module spm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 15
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/spm_sdiv.sv
// ============================================================================
// spm_sdiv - bit-serial restoring divider
// Produces one quotient bit per cycle. The dividend shifts out of the top of
// the quotient register while quotient bits shift in at the bottom. The
// starting remainder must be below the divisor.
// ============================================================================
module spm_sdiv #(
    parameter int QW = 20,
    parameter int DW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_rem_init,
    input  logic [QW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);

    localparam int CW = $clog2(QW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_q;

    logic [DW:0]   trial;
    logic          qbit;
    logic [DW-1:0] rem_step;

    // One restoring step: bring down the next dividend bit and try the divisor
    always_comb begin
        trial    = {r_rem, r_q[QW-1]};
        qbit     = (trial >= {1'b0, r_den});
        rem_step = qbit ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
    end

    // Control: count QW steps, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift one digit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= rem_step;
            r_q   <= {r_q[QW-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

>>> rtl/spm_lane.sv
// ============================================================================
// spm_lane - one servo channel: pot-to-PWM map and average divide
// Clamps the position at both pot limits, otherwise interpolates with a
// shift-add multiplier (one position bit per cycle) and the serial divider.
// The same divider later turns a running sum into an average.
// ============================================================================
module spm_lane #(
    parameter int SUMW = 20,
    parameter int FW   = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  spm_pkg::t_lane_ctl             i_ctl,
    input  logic [spm_pkg::POS_W-1:0]      i_pos,
    input  logic [spm_pkg::POS_W-1:0]      i_pot_low,
    input  logic [spm_pkg::POS_W-1:0]      i_pot_high,
    input  logic [spm_pkg::PWM_W-1:0]      i_lo,
    input  logic [spm_pkg::PWM_W-1:0]      i_hi,
    input  logic [SUMW-1:0]                i_sum,
    input  logic [FW-1:0]                  i_fill,
    output logic                           o_done,
    output logic [spm_pkg::PWM_W-1:0]      o_result
);

    localparam int PW = spm_pkg::PROD_W;
    localparam int MW = spm_pkg::PWM_W;
    localparam int XW = spm_pkg::POS_W;
    localparam int DW = spm_pkg::DIV_W;
    localparam int KW = $clog2(spm_pkg::MUL_STEPS);

    spm_pkg::t_lane_state r_state, n_state;

    logic [PW-1:0] r_p, n_p;
    logic [MW-1:0] r_m, n_m;
    logic          r_neg, n_neg;
    logic [MW-1:0] r_lo, n_lo;
    logic [DW-1:0] r_den, n_den;
    logic [KW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;
    logic [MW-1:0] r_res, n_res;

    logic          at_low;
    logic          at_high;
    logic [MW:0]   acc_sum;
    logic [PW-1:0] p_next;
    logic          mul_last;
    logic [MW-1:0] map_res;
    logic [MW-1:0] avg_res;

    logic            div_start;
    logic [DW-1:0]   div_rem_init;
    logic [SUMW-1:0] div_num;
    logic [DW-1:0]   div_den;
    logic            div_done;
    logic [SUMW-1:0] div_quo;

    spm_sdiv #(
        .QW (SUMW),
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_rem_init (div_rem_init),
        .i_num      (div_num),
        .i_den      (div_den),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // Shift-add multiply step, clamp tests and result forms
    always_comb begin
        at_low   = (i_pos <= i_pot_low);
        at_high  = (i_pos >= i_pot_high);
        acc_sum  = {1'b0, r_p[PW-1:XW]} + (r_p[0] ? {1'b0, r_m} : (MW + 1)'(0));
        p_next   = {acc_sum, r_p[XW-1:1]};
        mul_last = (r_cnt == KW'(spm_pkg::MUL_STEPS - 1));
        map_res  = r_neg ? (r_lo - div_quo[MW-1:0]) : (r_lo + div_quo[MW-1:0]);
        avg_res  = (div_quo > SUMW'(16'hFFFF)) ? 16'hFFFF : div_quo[MW-1:0];
    end

    // Lane sequencer: next state and divider launch
    always_comb begin
        n_state      = r_state;
        n_p          = r_p;
        n_m          = r_m;
        n_neg        = r_neg;
        n_lo         = r_lo;
        n_den        = r_den;
        n_cnt        = r_cnt;
        n_done       = r_done;
        n_res        = r_res;
        div_start    = 1'b0;
        div_rem_init = '0;
        div_num      = i_sum;
        div_den      = DW'(i_fill);
        unique case (r_state)
            spm_pkg::LN_IDLE: begin
                priority if (i_ctl.start_map) begin
                    n_done = 1'b0;
                    priority if (at_low) begin
                        n_res  = i_lo;
                        n_done = 1'b1;
                    end else if (at_high) begin
                        n_res  = i_hi;
                        n_done = 1'b1;
                    end else begin
                        n_p     = {MW'(0), i_pos - i_pot_low};
                        n_m     = (i_hi >= i_lo) ? (i_hi - i_lo) : (i_lo - i_hi);
                        n_neg   = (i_hi < i_lo);
                        n_lo    = i_lo;
                        n_den   = i_pot_high - i_pot_low;
                        n_cnt   = '0;
                        n_state = spm_pkg::LN_MUL;
                    end
                end else if (i_ctl.start_avg) begin
                    n_done    = 1'b0;
                    div_start = 1'b1;
                    n_state   = spm_pkg::LN_DIVA;
                end else begin
                    n_state = spm_pkg::LN_IDLE;
                end
            end
            spm_pkg::LN_MUL: begin
                n_p   = p_next;
                n_cnt = r_cnt + KW'(1);
                if (mul_last) begin
                    // Quotient fits 16 bits, so the bits above SUMW start as remainder
                    div_start    = 1'b1;
                    div_rem_init = DW'(p_next >> SUMW);
                    div_num      = SUMW'(p_next);
                    div_den      = r_den;
                    n_state      = spm_pkg::LN_DIVM;
                end
            end
            spm_pkg::LN_DIVM: begin
                if (div_done) begin
                    n_res   = map_res;
                    n_done  = 1'b1;
                    n_state = spm_pkg::LN_IDLE;
                end
            end
            spm_pkg::LN_DIVA: begin
                if (div_done) begin
                    n_res   = avg_res;
                    n_done  = 1'b1;
                    n_state = spm_pkg::LN_IDLE;
                end
            end
            default: begin
                n_state = spm_pkg::LN_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spm_pkg::LN_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_m   <= n_m;
        r_neg <= n_neg;
        r_lo  <= n_lo;
        r_den <= n_den;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

>>> rtl/servo_pwm_map_moving_average.sv
// ============================================================================
// servo_pwm_map_moving_average - four-channel servo PWM mapper with averaging
// Maps pot readings onto PWM compare values and optionally smooths them with
// a running-sum moving average of window 5, 10 or 15.
// ============================================================================
// Each lane has a bit-serial path: a shift-add multiplier that consumes one
// position bit per cycle, then one serial divider that makes one quotient
// bit per cycle, used once for the interpolation and, when the word is
// averaged, once more for the average. The divider's quotient is SUMW bits,
// where SUMW = 16 + clog2(MAX_WINDOW) (SUMW = 20 at the default MAX_WINDOW).
// All four lanes run side by side; a clamped channel skips its multiply and
// its interpolation divide. One word is in flight at a time, and the next
// word is taken while the finished result waits in the output register.
// The sample history lives in a RAM with one row per ring slot; per-slot
// valid bits clear at reset, so no clearing pass is needed.
module servo_pwm_map_moving_average #(
    parameter int MAX_WINDOW   = 15,
    parameter int NUM_CHANNELS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  spm_pkg::t_in_word                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output spm_pkg::t_out_word                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [spm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int NCH  = spm_pkg::NCH;
    localparam int MW   = spm_pkg::PWM_W;
    localparam int XW   = spm_pkg::POS_W;
    localparam int FILT = (NUM_CHANNELS < NCH) ? NUM_CHANNELS : NCH;
    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int RW   = $clog2(MAX_WINDOW + 1);
    localparam int SUMW = MW + $clog2(MAX_WINDOW);
    localparam int W5   = (spm_pkg::WIN_5 > MAX_WINDOW) ? MAX_WINDOW : spm_pkg::WIN_5;
    localparam int W10  = (spm_pkg::WIN_10 > MAX_WINDOW) ? MAX_WINDOW : spm_pkg::WIN_10;
    localparam int W15  = (spm_pkg::WIN_15 > MAX_WINDOW) ? MAX_WINDOW : spm_pkg::WIN_15;

    // Configuration registers
    logic [XW-1:0] r_pot_low;
    logic [XW-1:0] r_pot_high;
    logic [MW-1:0] r_pwm_low;
    logic [MW-1:0] r_pwm_high;
    logic [MW-1:0] r_grip_pwm_high;
    logic [1:0]    r_window_select;

    // Sequencer and filter state
    spm_pkg::t_spm_state r_state, n_state;
    logic                r_filt;
    logic [AW-1:0]       r_slot;
    logic [RW-1:0]       r_ring;
    logic                r_slot_vld [MAX_WINDOW];
    logic                r_old_vld;
    logic [SUMW-1:0]     r_sum  [FILT];
    logic [RW-1:0]       r_fill [FILT];
    logic [SUMW-1:0]     n_sum  [FILT];
    logic [RW-1:0]       n_fill [FILT];
    logic [MW-1:0]       old_smp [FILT];

    // Output register
    logic               r_out_valid;
    spm_pkg::t_out_word r_out_data;

    // Sequencer strobes
    logic accept;
    logic do_update;
    logic do_load;
    logic all_done;

    logic [RW-1:0] win_len;

    // Lane interface
    spm_pkg::t_lane_ctl lane_ctl  [NCH];
    logic [XW-1:0]      lane_pos  [NCH];
    logic [MW-1:0]      lane_hi   [NCH];
    logic [SUMW-1:0]    lane_sum  [NCH];
    logic [RW-1:0]      lane_fill [NCH];
    logic [MW-1:0]      lane_res  [NCH];
    logic [NCH-1:0]     lane_done;

    // History RAM
    logic [FILT*MW-1:0] ram_wdata;
    logic [FILT*MW-1:0] ram_rdata;

    // Decode window length, capped at the history depth
    always_comb begin
        unique case (r_window_select)
            spm_pkg::WSEL_5:  win_len = RW'(W5);
            spm_pkg::WSEL_10: win_len = RW'(W10);
            spm_pkg::WSEL_15: win_len = RW'(W15);
            default:          win_len = '0;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pot_low       <= spm_pkg::RST_POT_LOW;
            r_pot_high      <= spm_pkg::RST_POT_HIGH;
            r_pwm_low       <= spm_pkg::RST_PWM_LOW;
            r_pwm_high      <= spm_pkg::RST_PWM_HIGH;
            r_grip_pwm_high <= spm_pkg::RST_GRIP_PWM_HIGH;
            r_window_select <= spm_pkg::WSEL_NONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                spm_pkg::CFG_POT_LOW:       r_pot_low       <= i_cfg_data[XW-1:0];
                spm_pkg::CFG_POT_HIGH:      r_pot_high      <= i_cfg_data[XW-1:0];
                spm_pkg::CFG_PWM_LOW:       r_pwm_low       <= i_cfg_data;
                spm_pkg::CFG_PWM_HIGH:      r_pwm_high      <= i_cfg_data;
                spm_pkg::CFG_GRIP_PWM_HIGH: r_grip_pwm_high <= i_cfg_data;
                spm_pkg::CFG_WINDOW_SELECT: r_window_select <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Route fields to lanes; the grip lane has its own upper limit
    always_comb begin
        lane_pos[0] = i_in_data.base_position;
        lane_pos[1] = i_in_data.elbow_position;
        lane_pos[2] = i_in_data.wrist_position;
        lane_pos[3] = i_in_data.grip_position;
        lane_hi[0]  = r_pwm_high;
        lane_hi[1]  = r_pwm_high;
        lane_hi[2]  = r_pwm_high;
        lane_hi[3]  = r_grip_pwm_high;
    end

    // Next running sum and fill count of each filtered channel
    always_comb begin
        for (int c = 0; c < FILT; c++) begin
            old_smp[c] = r_old_vld ? ram_rdata[c*MW +: MW] : '0;
            n_sum[c]   = r_sum[c] - SUMW'(old_smp[c]) + SUMW'(lane_res[c]);
            n_fill[c]  = (r_fill[c] < win_len) ? (r_fill[c] + RW'(1)) : win_len;
            ram_wdata[c*MW +: MW] = lane_res[c];
        end
    end

    genvar g;
    generate
        for (g = 0; g < NCH; g++) begin : g_lane
            assign lane_ctl[g].start_map = accept;
            if (g < FILT) begin : g_filt
                assign lane_ctl[g].start_avg = do_update;
                assign lane_sum[g]           = n_sum[g];
                assign lane_fill[g]          = n_fill[g];
            end else begin : g_pass
                assign lane_ctl[g].start_avg = 1'b0;
                assign lane_sum[g]           = '0;
                assign lane_fill[g]          = '0;
            end

            spm_lane #(
                .SUMW (SUMW),
                .FW   (RW)
            ) u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (lane_ctl[g]),
                .i_pos      (lane_pos[g]),
                .i_pot_low  (r_pot_low),
                .i_pot_high (r_pot_high),
                .i_lo       (r_pwm_low),
                .i_hi       (lane_hi[g]),
                .i_sum      (lane_sum[g]),
                .i_fill     (lane_fill[g]),
                .o_done     (lane_done[g]),
                .o_result   (lane_res[g])
            );
        end
    endgenerate

    assign all_done = &lane_done;

    spm_ram #(
        .WIDTH (FILT * MW),
        .DEPTH (MAX_WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (do_update),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (r_ring[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Sequencer: next state and strobes
    always_comb begin
        n_state    = r_state;
        accept     = 1'b0;
        do_update  = 1'b0;
        do_load    = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            spm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    accept  = 1'b1;
                    n_state = spm_pkg::ST_MAP;
                end
            end
            spm_pkg::ST_MAP: begin
                if (all_done) begin
                    if (r_filt) begin
                        do_update = 1'b1;
                        n_state   = spm_pkg::ST_AVG;
                    end else begin
                        n_state = spm_pkg::ST_DONE;
                    end
                end
            end
            spm_pkg::ST_AVG: begin
                if (all_done && (r_ring < win_len)) begin
                    n_state = spm_pkg::ST_DONE;
                end
            end
            spm_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    do_load = 1'b1;
                    n_state = spm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spm_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer and filter state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spm_pkg::ST_IDLE;
            r_ring  <= '0;
            for (int s = 0; s < MAX_WINDOW; s++) begin
                r_slot_vld[s] <= 1'b0;
            end
            for (int c = 0; c < FILT; c++) begin
                r_sum[c]  <= '0;
                r_fill[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (do_update) begin
                r_slot_vld[r_slot] <= 1'b1;
                r_ring             <= RW'(r_slot) + RW'(1);
                for (int c = 0; c < FILT; c++) begin
                    r_sum[c]  <= n_sum[c];
                    r_fill[c] <= n_fill[c];
                end
            end else if ((r_state == spm_pkg::ST_AVG) && (r_ring >= win_len)) begin
                // Wrap the ring index modulo the window, one subtract per cycle
                r_ring <= r_ring - win_len;
            end
        end
    end

    // Hold the per-word filter decision and slot
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_filt    <= i_in_data.filter_enable && (win_len != '0);
            r_slot    <= r_ring[AW-1:0];
            r_old_vld <= r_slot_vld[r_ring[AW-1:0]];
        end
    end

    // Output register: load the finished word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_out_data.base_compare  <= lane_res[0];
            r_out_data.elbow_compare <= lane_res[1];
            r_out_data.wrist_compare <= lane_res[2];
            r_out_data.grip_compare  <= lane_res[3];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
